### sv/pfa_pkg.sv
package pfa_pkg;

    // table geometry
    localparam int NUM_PARTITIONS  = 128;
    localparam int SIZE_BITS       = 16;
    localparam int ADDR_BITS       = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    // fixed field widths of the request and result
    localparam int IDX_FIELD_BITS  = 7;
    localparam int SIZE_FIELD_BITS = 16;
    localparam int CMP_BITS        = (SIZE_BITS > SIZE_FIELD_BITS) ? SIZE_BITS : SIZE_FIELD_BITS;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // placement policies, code 3 means nothing and fails
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SIZE_BITS-1:0] size_t;

    typedef struct packed {
        logic                       kind;
        logic [1:0]                 policy;
        logic [IDX_FIELD_BITS-1:0]  entry_index;
        logic [SIZE_FIELD_BITS-1:0] entry_size;
        logic [SIZE_FIELD_BITS-1:0] request_size;
    } in_item_t;

    typedef struct packed {
        logic                       granted;
        logic [IDX_FIELD_BITS-1:0]  granted_index;
        logic [SIZE_FIELD_BITS-1:0] granted_size;
    } out_item_t;

    // one stored partition
    typedef struct packed {
        logic  taken;
        size_t size;
    } word_t;

    // one entry returned by the scan
    typedef struct packed {
        logic  vld;
        logic  taken;
        addr_t index;
        size_t size;
    } entry_t;

    // running choice of the scan
    typedef struct packed {
        logic  found;
        addr_t index;
        size_t size;
    } pick_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

### sv/pfa_table.sv
module pfa_table
    import pfa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_en,
    input  addr_t wr_addr,
    input  word_t wr_data,
    input  logic  rd_en,
    input  addr_t rd_addr,
    output word_t rd_data
);

    word_t                    mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] written_reg;
    word_t                    rd_word_reg;
    logic                     rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // written marks stand in for the all-zero reset of the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

### sv/pfa_select.sv
module pfa_select
    import pfa_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [1:0]                 policy,
    input  logic [SIZE_FIELD_BITS-1:0] request_size,
    input  entry_t                     entry,
    output pick_t                      pick
);

    pick_t pick_reg;
    pick_t pick_next;
    logic  fits;
    logic  better;

    always_comb begin
        fits = entry.vld && !entry.taken
            && (CMP_BITS'(entry.size) >= CMP_BITS'(request_size));
        better = 1'b0;
        if (!pick_reg.found) begin
            better = 1'b1;
        end else begin
            case (policy)
                POL_BEST:  better = entry.size < pick_reg.size;
                POL_WORST: better = entry.size > pick_reg.size;
                default:   better = 1'b0;
            endcase
        end
    end

    always_comb begin
        pick_next = pick_reg;
        if (start) begin
            pick_next = '0;
        end else if (fits && better) begin
            pick_next.found = 1'b1;
            pick_next.index = entry.index;
            pick_next.size  = entry.size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pick_reg <= '0;
        end else begin
            pick_reg <= pick_next;
        end
    end

    assign pick = pick_reg;

endmodule

### sv/partition_fit_allocator.sv
// channel  | direction | ports                      | content
// request  | in        | s_valid, s_ready, s_data   | load size or allocate request
// result   | out       | m_valid, m_ready, m_data   | one per allocate request
//
// a load request writes the table directly
// an allocate result follows a scan: after acceptance, one table read per partition goes
// through the single read port, each read word is registered in the table and folded into
// the select register, then the select cycle loads the result; the next request waits for idle
// reset clears the written marks at once, so no clearing pass is needed
// a waiting result does not block loads; an allocate holds in its select cycle
// until the output register is free
module partition_fit_allocator
    import pfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam addr_t LAST_ADDR = ADDR_BITS'(NUM_PARTITIONS - 1);

    state_t    state_reg, state_next;
    logic      issuing_reg, issuing_next;
    addr_t     scan_addr_reg, scan_addr_next;
    logic      rd_pend_reg, rd_last_reg;
    addr_t     rd_idx_reg;
    logic [1:0] policy_reg;
    logic [SIZE_FIELD_BITS-1:0] req_reg;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;

    logic      accept;
    logic      load_in_range;
    logic      out_free;
    logic      issue;
    logic      sel_start;
    logic      out_load;
    logic      wr_en;
    addr_t     wr_addr;
    word_t     wr_data;
    word_t     rd_data;
    entry_t    entry;
    pick_t     pick;

    assign accept        = s_valid && s_ready;
    assign load_in_range = 32'(s_data.entry_index) < NUM_PARTITIONS;
    assign out_free      = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.kind == KIND_ALLOC) begin
                    // unused policy code skips the scan and fails
                    if (s_data.policy == POL_FIRST || s_data.policy == POL_BEST
                        || s_data.policy == POL_WORST) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_pend_reg && rd_last_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the control
    always_comb begin
        s_ready   = 1'b0;
        sel_start = 1'b0;
        issue     = 1'b0;
        out_load  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = ADDR_BITS'(s_data.entry_index);
        wr_data   = '{taken: 1'b0, size: SIZE_BITS'(s_data.entry_size)};
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                sel_start = accept && s_data.kind == KIND_ALLOC;
                // load writes size and clears the taken mark
                wr_en     = accept && s_data.kind == KIND_LOAD && load_in_range;
            end
            ST_SCAN: begin
                issue = issuing_reg;
            end
            ST_DONE: begin
                out_load = out_free;
                // mark the winner taken once the scan is over
                wr_en    = out_free && pick.found;
                wr_addr  = pick.index;
                wr_data  = '{taken: 1'b1, size: pick.size};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // scan address sequencing, only when a real scan follows
    always_comb begin
        issuing_next   = issuing_reg;
        scan_addr_next = scan_addr_reg;
        if (sel_start && state_next == ST_SCAN) begin
            issuing_next   = 1'b1;
            scan_addr_next = '0;
        end else if (issue) begin
            if (scan_addr_reg == LAST_ADDR) begin
                issuing_next = 1'b0;
            end else begin
                scan_addr_next = scan_addr_reg + 1'b1;
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issuing_reg   <= 1'b0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issuing_reg   <= issuing_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= issue;
            rd_last_reg   <= issue && scan_addr_reg == LAST_ADDR;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_addr_reg;
        if (sel_start) begin
            policy_reg <= s_data.policy;
            req_reg    <= s_data.request_size;
        end
        if (out_load) begin
            m_data_reg.granted       <= pick.found;
            m_data_reg.granted_index <= pick.found ? IDX_FIELD_BITS'(pick.index) : '0;
            m_data_reg.granted_size  <= pick.found ? SIZE_FIELD_BITS'(pick.size) : '0;
        end
    end

    pfa_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    assign entry = '{vld: rd_pend_reg, taken: rd_data.taken, index: rd_idx_reg,
                     size: rd_data.size};

    pfa_select u_select (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (sel_start),
        .policy       (policy_reg),
        .request_size (req_reg),
        .entry        (entry),
        .pick         (pick)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a result only appears out of the select cycle
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside select cycle");

    // failed request reports all-zero fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.granted) |->
            (m_data.granted_index == '0 && m_data.granted_size == '0))
        else $error("failure result carries nonzero fields");

    // scan reads never collide with a table write
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(issue && wr_en))
        else $error("table read and write in the same cycle");

    // no read is still outstanding when the winner is chosen
    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (!issuing_reg && !rd_pend_reg))
        else $error("select cycle with scan still running");
`endif

endmodule
